@@ hw/rtl/mi3_pkg.sv @@
// Shared widths, types and constants of the 3x3 matrix inverse.
package mi3_pkg;

  localparam int EW = 32;            // element width
  localparam int CW = 2 * EW + 1;    // cofactor width, signed
  localparam int DW = 3 * EW + 3;    // determinant width, signed
  localparam int QB = 32;            // quotient bits before overflow
  localparam int TW = 31;            // tolerance register width

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;
  typedef logic [CW-1:0]        cmag_t;
  typedef logic [DW-1:0]        dmag_t;
  typedef logic [TW-1:0]        tol_t;

  localparam tol_t TOL_RESET = 31'd66;
  localparam logic [EW-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] LIM_NEG = 32'h8000_0000;

  typedef struct packed {
    logic [8:0][EW-1:0] inv;
    logic               singular;
    logic               saturated;
  } res_t;

endpackage

@@ hw/rtl/matrix3x3_inverse.sv @@
// Top level of the 3x3 fixed-point matrix inverse by adjugate.
//
// Input channel in_*: one 3x3 matrix of signed fixed-point elements per
// transfer (in_valid high, in_stall low at a rising edge). Result channel
// out_*: nine inverse elements, a singular flag and a saturated flag.
// Configuration: cfg_we writes cfg_wdata into the singular tolerance; write
// it only while no matrix is in flight.
//
// Stages from an input transfer to out_*: 2 cofactor stages, 3 determinant
// stages, 1 magnitude/singular stage, 34 divider stages (overflow check, one
// quotient bit per stage, saturate) and the output register. Throughput: one
// matrix per cycle while in_stall is low, set by the nine parallel divider
// pipelines.
//
// Reset (rst_n low, synchronous) empties the pipeline and the output and
// skid registers and loads the tolerance with 66. When the receiver holds
// out_stall, the output register holds its result, the next result from the
// pipeline lands in the skid register, and in_stall rises in the cycle after;
// the whole pipeline freezes until the skid register drains.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [mi3_pkg::TW-1:0]   cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       in_m00,
  input  logic signed [31:0]       in_m01,
  input  logic signed [31:0]       in_m02,
  input  logic signed [31:0]       in_m10,
  input  logic signed [31:0]       in_m11,
  input  logic signed [31:0]       in_m12,
  input  logic signed [31:0]       in_m20,
  input  logic signed [31:0]       in_m21,
  input  logic signed [31:0]       in_m22,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [31:0]       out_inv00,
  output logic signed [31:0]       out_inv01,
  output logic signed [31:0]       out_inv02,
  output logic signed [31:0]       out_inv10,
  output logic signed [31:0]       out_inv11,
  output logic signed [31:0]       out_inv12,
  output logic signed [31:0]       out_inv20,
  output logic signed [31:0]       out_inv21,
  output logic signed [31:0]       out_inv22,
  output logic                     out_singular,
  output logic                     out_saturated
);

  localparam int PRE  = 6;                 // stages before the dividers
  localparam int DIVL = mi3_pkg::QB + 2;   // divider latency
  localparam int VL   = PRE + DIVL;

  mi3_pkg::tol_t  tol_r;
  logic           en;

  mi3_pkg::elem_t m_in [9];
  mi3_pkg::cof_t  cof [9];
  mi3_pkg::elem_t row0 [3];
  mi3_pkg::det_t  det;
  mi3_pkg::cof_t  cof_d [9];

  mi3_pkg::dmag_t tol_sh;
  mi3_pkg::dmag_t adet_r;
  mi3_pkg::cmag_t cmag_r [9];
  logic           neg_r [9];
  logic           sing_r;

  mi3_pkg::elem_t quo [9];
  logic [8:0]     sat_v;

  logic [VL-1:0]   v_r;
  logic [DIVL-1:0] sg_r;

  mi3_pkg::res_t  p_res;
  logic           p_valid;
  mi3_pkg::res_t  out_r;
  mi3_pkg::res_t  skid_r;
  logic           out_vld_r;
  logic           skid_vld_r;

  // tolerance register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= mi3_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  // advance the pipeline whenever the skid register is empty
  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  assign m_in[0] = in_m00;
  assign m_in[1] = in_m01;
  assign m_in[2] = in_m02;
  assign m_in[3] = in_m10;
  assign m_in[4] = in_m11;
  assign m_in[5] = in_m12;
  assign m_in[6] = in_m20;
  assign m_in[7] = in_m21;
  assign m_in[8] = in_m22;

  mi3_cofactor u_cof (
    .clk  (clk),
    .en   (en),
    .m    (m_in),
    .c    (cof),
    .row0 (row0)
  );

  mi3_det u_det (
    .clk  (clk),
    .en   (en),
    .c    (cof),
    .row0 (row0),
    .det  (det),
    .c_d  (cof_d)
  );

  // Magnitudes, signs and the singular test. The tolerance is compared at
  // the determinant's scale; a zero determinant is singular even when the
  // tolerance is zero.
  assign tol_sh = mi3_pkg::dmag_t'(tol_r) << (2 * FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      adet_r <= det[mi3_pkg::DW-1] ? mi3_pkg::dmag_t'(-det) : mi3_pkg::dmag_t'(det);
      sing_r <= (det == '0) ||
                ((det < $signed(tol_sh)) && (det > -$signed(tol_sh)));
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        cmag_r[k] <= cof_d[k][mi3_pkg::CW-1] ? mi3_pkg::cmag_t'(-cof_d[k])
                                             : mi3_pkg::cmag_t'(cof_d[k]);
        neg_r[k]  <= cof_d[k][mi3_pkg::CW-1] ^ det[mi3_pkg::DW-1];
      end
    end

    mi3_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk (clk),
      .en  (en),
      .num (cmag_r[k]),
      .den (adet_r),
      .neg (neg_r[k]),
      .quo (quo[k]),
      .sat (sat_v[k])
    );
  end

  // valid bits and the singular flag travel beside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VL-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_r <= {sg_r[DIVL-2:0], sing_r};
    end
  end

  // zero the result of a singular matrix and drop its saturation
  always_comb begin
    p_valid = v_r[VL-1];
    for (int k = 0; k < 9; k++) begin
      p_res.inv[k] = sg_r[DIVL-1] ? '0 : quo[k];
    end
    p_res.singular  = sg_r[DIVL-1];
    p_res.saturated = !sg_r[DIVL-1] && (|sat_v);
  end

  // Output register with one skid entry: a stalled result holds, the next
  // transfer from the pipeline parks in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!skid_vld_r) begin
      if (out_vld_r && out_stall) begin
        skid_vld_r <= p_valid;
      end else begin
        out_vld_r <= p_valid;
      end
    end else if (!out_stall) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      if (out_vld_r && out_stall) begin
        skid_r <= p_res;
      end else begin
        out_r <= p_res;
      end
    end else if (!out_stall) begin
      out_r <= skid_r;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_inv00     = out_r.inv[0];
  assign out_inv01     = out_r.inv[1];
  assign out_inv02     = out_r.inv[2];
  assign out_inv10     = out_r.inv[3];
  assign out_inv11     = out_r.inv[4];
  assign out_inv12     = out_r.inv[5];
  assign out_inv20     = out_r.inv[6];
  assign out_inv21     = out_r.inv[7];
  assign out_inv22     = out_r.inv[8];
  assign out_singular  = out_r.singular;
  assign out_saturated = out_r.saturated;

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid register full with empty output register");

  // a released output drains the skid entry in the next cycle
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_stall |=> !skid_vld_r && out_vld_r)
    else $error("skid register did not drain");

  // a pipeline result is never dropped when the output can take it
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !skid_vld_r && p_valid && !(out_vld_r && out_stall) |=> out_vld_r)
    else $error("pipeline result lost");

  // singular results carry zeros on the diagonal and no saturation
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.singular |->
      !out_r.saturated && (out_r.inv[0] == '0) && (out_r.inv[4] == '0) &&
      (out_r.inv[8] == '0))
    else $error("singular result not cleared");

endmodule

@@ hw/rtl/mi3_cofactor.sv @@
// Two-stage cofactor pipeline: element products, then differences.
module mi3_cofactor (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t m [9],
  output mi3_pkg::cof_t  c [9],
  output mi3_pkg::elem_t row0 [3]
);

  localparam int AI [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int BI [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CI [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int DI [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [2*mi3_pkg::EW-1:0] pa_r [9];
  logic signed [2*mi3_pkg::EW-1:0] pb_r [9];
  mi3_pkg::cof_t  c_r [9];
  mi3_pkg::elem_t r0a_r [3];
  mi3_pkg::elem_t r0b_r [3];

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (en) begin
        pa_r[k] <= m[AI[k]] * m[BI[k]];
        pb_r[k] <= m[CI[k]] * m[DI[k]];
        c_r[k]  <= mi3_pkg::cof_t'(pa_r[k]) - mi3_pkg::cof_t'(pb_r[k]);
      end
    end
    assign c[k] = c_r[k];
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        r0a_r[j] <= m[j];
        r0b_r[j] <= r0a_r[j];
      end
    end
    assign row0[j] = r0b_r[j];
  end

endmodule

@@ hw/rtl/mi3_det.sv @@
// Three-stage determinant pipeline along row 0, cofactors delayed alongside.
module mi3_det (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::cof_t  c [9],
  input  mi3_pkg::elem_t row0 [3],
  output mi3_pkg::det_t  det,
  output mi3_pkg::cof_t  c_d [9]
);

  localparam int EW = mi3_pkg::EW;
  localparam int CW = mi3_pkg::CW;

  logic signed [2*EW:0] plo_r [3];
  logic signed [2*EW:0] phi_r [3];
  mi3_pkg::det_t t_r [3];
  mi3_pkg::det_t det_r;
  mi3_pkg::cof_t cd1_r [9];
  mi3_pkg::cof_t cd2_r [9];
  mi3_pkg::cof_t cd3_r [9];

  // split each cofactor of row 0 into an unsigned low word and a signed high part
  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk) begin
      if (en) begin
        plo_r[j] <= row0[j] * $signed({1'b0, c[3*j][EW-1:0]});
        phi_r[j] <= row0[j] * $signed(c[3*j][CW-1:EW]);
        t_r[j]   <= (mi3_pkg::det_t'(phi_r[j]) <<< EW) + mi3_pkg::det_t'(plo_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= t_r[0] + t_r[1] + t_r[2];
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        cd1_r[k] <= c[k];
        cd2_r[k] <= cd1_r[k];
        cd3_r[k] <= cd2_r[k];
      end
    end
    assign c_d[k] = cd3_r[k];
  end

  assign det = det_r;

endmodule

@@ hw/rtl/mi3_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation.
module mi3_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::cmag_t num,
  input  mi3_pkg::dmag_t den,
  input  logic           neg,
  output mi3_pkg::elem_t quo,
  output logic           sat
);

  localparam int QB = mi3_pkg::QB;
  localparam int DW = mi3_pkg::DW;
  localparam int EW = mi3_pkg::EW;
  localparam int NW = mi3_pkg::CW + 2 * FRAC_BITS;

  logic [NW-1:0]    nfull;
  logic [NW-QB-1:0] nhi;

  logic [DW-1:0] rem_r [QB+1];
  logic [DW-1:0] d_r   [QB+1];
  logic [QB-1:0] nlo_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          ovf_r [QB+1];
  logic          neg_r [QB+1];

  logic [EW-1:0] lim;
  logic [EW-1:0] mag;
  logic          sat_c;
  logic [EW-1:0] res_r;
  logic          sat_r;

  assign nfull = {num, {(2*FRAC_BITS){1'b0}}};
  assign nhi   = nfull[NW-1:QB];

  // quotient beyond QB bits shows up as high part not below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(nhi);
      d_r[0]   <= den;
      nlo_r[0] <= nfull[QB-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (nhi >= den);
      neg_r[0] <= neg;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[i-1], nlo_r[i-1][QB-i]};
    assign ge    = (trial >= {1'b0, d_r[i-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DW'(trial - {1'b0, d_r[i-1]}) : DW'(trial);
        d_r[i]   <= d_r[i-1];
        nlo_r[i] <= nlo_r[i-1];
        q_r[i]   <= {q_r[i-1][QB-2:0], ge};
        ovf_r[i] <= ovf_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  always_comb begin
    lim   = neg_r[QB] ? mi3_pkg::LIM_NEG : mi3_pkg::LIM_POS;
    sat_c = ovf_r[QB] || (EW'(q_r[QB]) > lim);
    mag   = sat_c ? lim : EW'(q_r[QB]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[QB] ? (~mag + 1'b1) : mag;
      sat_r <= sat_c;
    end
  end

  assign quo = mi3_pkg::elem_t'(res_r);
  assign sat = sat_r;

endmodule
